// ===== design/bffa_pkg.sv =====
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared widths and status codes of the bitmap first-fit allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

    // request and response field widths
    localparam int SIZE_W   = 16;
    localparam int STATUS_W = 2;
    localparam int OFF_W    = 15;

    // rounded-up block count of a request, up to 2**SIZE_W
    localparam int NEED_W   = SIZE_W + 1;

    // response status codes
    localparam logic [STATUS_W-1:0] STATUS_ALLOCATED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ZERO_SIZE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_SPACE  = 2'd2;

endpackage

// ===== design/bitmap_first_fit_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_first_fit_allocator
// rsp_valid is registered in S_FINISH, once the output register is free, after
// the request passes S_DIV (only for a non power of two BLOCK_BYTES, reciprocal
// multiply), S_CHECK, S_SCAN (up to MAP_WORDS bitmap words, one per cycle), S_MARK
// (the words marked) and S_CALC; a failure skips both, a zero size goes to S_FINISH.
// One request in flight; the next is taken while the last response waits.
// Reset: a clearing pass zeroes the bitmap one word per cycle, req_ready low.
// ----------------------------------------------------------------------------
module bitmap_first_fit_allocator
    import bffa_pkg::*;
#(
    parameter int NUM_BLOCKS    = 4096,
    parameter int BLOCK_BYTES   = 8,
    parameter int MAP_WORD_BITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic [SIZE_W-1:0]   size_bytes,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output logic [STATUS_W-1:0] status,
    output logic [OFF_W-1:0]    byte_offset
);

    localparam int W         = MAP_WORD_BITS;
    localparam int MAP_WORDS = (NUM_BLOCKS + W - 1) / W;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BW        = $clog2(W);
    localparam int RUN_W     = $clog2(MAP_WORDS * W + 1);
    localparam int BIDX_W    = $clog2(MAP_WORDS * W);
    localparam int TAIL_BITS = NUM_BLOCKS - (MAP_WORDS - 1) * W;
    localparam logic [W-1:0] TAIL_USED = {W{1'b1}} << TAIL_BITS;
    localparam logic [AW-1:0] LAST_W   = AW'(MAP_WORDS - 1);
    localparam bit   BB_POW2 = (BLOCK_BYTES & (BLOCK_BYTES - 1)) == 0;
    localparam int   BB_SH   = $clog2(BLOCK_BYTES);
    localparam logic [SIZE_W-1:0] BB_MASK = SIZE_W'(BLOCK_BYTES - 1);
    localparam int   DIV_NUM_W  = SIZE_W + 1;
    localparam int   DIV_SH     = DIV_NUM_W + BB_SH;
    localparam int   DIV_PROD_W = 2 * DIV_NUM_W + 1;
    localparam longint DIV_RECIP =
        ((longint'(1) << DIV_SH) + longint'(BLOCK_BYTES) - 1) / longint'(BLOCK_BYTES);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_CHECK,
        S_SCAN,
        S_MARK,
        S_CALC,
        S_FINISH
    } state_t;

    // control and datapath registers
    state_t                state_reg, state_next;
    logic [SIZE_W-1:0]     dq_reg, dq_next;
    logic [NEED_W-1:0]     need_full_reg, need_full_next;
    logic [RUN_W-1:0]      need_reg, need_next;
    logic [RUN_W-1:0]      run_reg, run_next;
    logic [AW-1:0]         scan_w_reg, scan_w_next;
    logic [BW-1:0]         end_b_reg, end_b_next;
    logic [AW-1:0]         mark_w_reg, mark_w_next;
    logic [BW-1:0]         hi_reg, hi_next;
    logic [RUN_W-1:0]      rem_reg, rem_next;
    logic [BIDX_W-1:0]     start_reg, start_next;
    logic [STATUS_W-1:0]   stat_reg, stat_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [OFF_W-1:0]      byte_offset_reg, byte_offset_next;

    // bitmap memory ports
    logic [W-1:0]          used_map [MAP_WORDS];
    logic [AW-1:0]         mem_raddr;
    logic [W-1:0]          mem_rdata;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [W-1:0]          mem_wdata;

    // scan and mark datapath
    logic [W-1:0]          used_w;
    logic [RUN_W-1:0]      lane_run [W];
    logic [W-1:0]          hit_vec;
    logic [BW-1:0]         hit_b;
    logic [NEED_W-1:0]     need_pow2;
    logic [DIV_NUM_W-1:0]  div_num;
    logic [DIV_PROD_W-1:0] div_prod;
    logic [BW-1:0]         mark_lo;
    logic [BW:0]           mark_cnt;
    logic [W-1:0]          mark_mask;
    logic                  mark_done;
    logic [RUN_W-1:0]      end_blk;

    assign req_ready   = (state_reg == S_IDLE);
    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign byte_offset = byte_offset_reg;

    // bitmap store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            used_map[mem_waddr] <= mem_wdata;
        end
        mem_rdata <= used_map[mem_raddr];
    end

    // block count for a power of two block size
    assign need_pow2 = NEED_W'(size_bytes >> BB_SH) + NEED_W'(|(size_bytes & BB_MASK));

    // rounded-up block count by reciprocal multiplication
    assign div_num  = DIV_NUM_W'(dq_reg) + DIV_NUM_W'(BLOCK_BYTES - 1);
    assign div_prod = DIV_PROD_W'(div_num) * DIV_PROD_W'(DIV_RECIP);

    // per-bit free run length ending at each bit, carried in from lower words
    always_comb
    begin
        logic          any_used;
        logic [BW-1:0] pos;
        used_w = mem_rdata | ((scan_w_reg == LAST_W) ? TAIL_USED : '0);
        for (int b = 0; b < W; b++)
        begin
            any_used = 1'b0;
            pos      = '0;
            for (int j = 0; j <= b; j++)
            begin
                if (used_w[j])
                begin
                    any_used = 1'b1;
                    pos      = BW'(j);
                end
            end
            lane_run[b] = any_used ? (RUN_W'(b) - RUN_W'(pos)) : (run_reg + RUN_W'(b + 1));
            hit_vec[b]  = !used_w[b] && (lane_run[b] >= need_reg);
        end
    end

    // lowest bit that completes a free run
    always_comb
    begin
        hit_b = '0;
        for (int b = W - 1; b >= 0; b--)
        begin
            if (hit_vec[b])
            begin
                hit_b = BW'(b);
            end
        end
    end

    // bits of the current word covered by the run, walking down from its end
    always_comb
    begin
        if (rem_reg > RUN_W'(hi_reg))
        begin
            mark_lo = '0;
        end
        else
        begin
            mark_lo = hi_reg - BW'(rem_reg) + BW'(1);
        end
        mark_cnt  = (BW+1)'(hi_reg) - (BW+1)'(mark_lo) + (BW+1)'(1);
        mark_done = (rem_reg == RUN_W'(mark_cnt));
        for (int j = 0; j < W; j++)
        begin
            mark_mask[j] = (BW'(j) >= mark_lo) && (BW'(j) <= hi_reg);
        end
    end

    // last block of the run
    assign end_blk = RUN_W'(RUN_W'(scan_w_reg) * RUN_W'(W)) + RUN_W'(end_b_reg);

    // next-state logic
    always_comb
    begin
        state_next       = state_reg;
        dq_next          = dq_reg;
        need_full_next   = need_full_reg;
        need_next        = need_reg;
        run_next         = run_reg;
        scan_w_next      = scan_w_reg;
        end_b_next       = end_b_reg;
        mark_w_next      = mark_w_reg;
        hi_next          = hi_reg;
        rem_next         = rem_reg;
        start_next       = start_reg;
        stat_next        = stat_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;
        status_next      = status_reg;
        byte_offset_next = byte_offset_reg;
        mem_raddr        = '0;
        mem_we           = 1'b0;
        mem_waddr        = mark_w_reg;
        mem_wdata        = mem_rdata | mark_mask;

        case (state_reg)
            // zero the bitmap one word a cycle
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = scan_w_reg;
                mem_wdata = '0;
                if (scan_w_reg == LAST_W)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    scan_w_next = scan_w_reg + AW'(1);
                end
            end

            // request beat
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (size_bytes == '0)
                    begin
                        stat_next  = STATUS_ZERO_SIZE;
                        state_next = S_FINISH;
                    end
                    else if (BB_POW2)
                    begin
                        need_full_next = need_pow2;
                        state_next     = S_CHECK;
                    end
                    else
                    begin
                        dq_next    = size_bytes;
                        state_next = S_DIV;
                    end
                end
            end

            // block count for other block sizes
            S_DIV:
            begin
                need_full_next = NEED_W'(div_prod >> DIV_SH);
                state_next     = S_CHECK;
            end

            // reject oversize requests, start the scan at word 0
            S_CHECK:
            begin
                if (32'(need_full_reg) > 32'(NUM_BLOCKS))
                begin
                    stat_next  = STATUS_NO_SPACE;
                    state_next = S_FINISH;
                end
                else
                begin
                    need_next   = RUN_W'(need_full_reg);
                    run_next    = '0;
                    scan_w_next = '0;
                    mem_raddr   = '0;
                    state_next  = S_SCAN;
                end
            end

            // one bitmap word a cycle
            S_SCAN:
            begin
                if (|hit_vec)
                begin
                    end_b_next  = hit_b;
                    mark_w_next = scan_w_reg;
                    hi_next     = hit_b;
                    rem_next    = need_reg;
                    mem_raddr   = scan_w_reg;
                    state_next  = S_MARK;
                end
                else if (scan_w_reg == LAST_W)
                begin
                    stat_next  = STATUS_NO_SPACE;
                    state_next = S_FINISH;
                end
                else
                begin
                    scan_w_next = scan_w_reg + AW'(1);
                    mem_raddr   = scan_w_reg + AW'(1);
                    run_next    = lane_run[W-1];
                end
            end

            // read-modify-write the run's words from its end downward
            S_MARK:
            begin
                mem_we = 1'b1;
                if (mark_done)
                begin
                    stat_next  = STATUS_ALLOCATED;
                    state_next = S_CALC;
                end
                else
                begin
                    mark_w_next = mark_w_reg - AW'(1);
                    mem_raddr   = mark_w_reg - AW'(1);
                    hi_next     = BW'(W - 1);
                    rem_next    = rem_reg - RUN_W'(mark_cnt);
                end
            end

            // first block of the run
            S_CALC:
            begin
                start_next = BIDX_W'(end_blk + RUN_W'(1) - need_reg);
                state_next = S_FINISH;
            end

            // response beat into the output register
            S_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = stat_reg;
                    if (stat_reg == STATUS_ALLOCATED)
                    begin
                        byte_offset_next = OFF_W'(OFF_W'(start_reg) * OFF_W'(BLOCK_BYTES));
                    end
                    else
                    begin
                        byte_offset_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            scan_w_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            scan_w_reg      <= scan_w_next;
            rsp_valid_reg   <= rsp_valid_next;
            dq_reg          <= dq_next;
            need_full_reg   <= need_full_next;
            need_reg        <= need_next;
            run_reg         <= run_next;
            end_b_reg       <= end_b_next;
            mark_w_reg      <= mark_w_next;
            hi_reg          <= hi_next;
            rem_reg         <= rem_next;
            start_reg       <= start_next;
            stat_reg        <= stat_next;
            status_reg      <= status_next;
            byte_offset_reg <= byte_offset_next;
        end
    end

    // bitmap is written only by the clearing pass or the marking pass
    a_write_owner: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_CLEAR || state_reg == S_MARK))
        else $error("bitmap written outside clear or mark");

    // every bit claimed by the marking pass was free
    a_mark_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MARK) |-> ((mem_rdata & mark_mask) == '0))
        else $error("run overlaps a used block");

    // marking always claims at least one bit
    a_mark_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MARK) |-> (mark_mask != '0))
        else $error("empty mark mask");

    // failed requests carry a zero offset
    a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status != STATUS_ALLOCATED) |-> (byte_offset == '0))
        else $error("offset set on failed request");

    // a new response loads only once the previous beat is gone
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_ready) |=> rsp_valid_reg)
        else $error("pending response dropped");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the bitmap first-fit allocator against a behavioral first-fit
// predictor. Directed size extremes come first. Output back-pressure and a
// drained pause follow, then a long random mix of mostly small requests
// that fills the pool. A final pass probes the end of the store.
// ----------------------------------------------------------------------------
module testbench;
    import bffa_pkg::*;

    // block configuration, kept at the design defaults
    localparam int NUM_BLOCKS    = 4096;
    localparam int BLOCK_BYTES   = 8;
    localparam int MAP_WORD_BITS = 32;
    localparam int MAP_WORDS     = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int POOL_BYTES    = NUM_BLOCKS * BLOCK_BYTES;

    // worst-case request latency plus margin, and bound on a drain wait
    localparam int TAIL_CYCLES   = 300;
    localparam int DRAIN_LIMIT   = 40000;
    localparam int MAX_GAP       = 18;
    localparam int RANDOM_ITEMS  = 1890;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OFF_W-1:0]    offset;
    } alloc_result_t;

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_ready;
    logic [SIZE_W-1:0]   size_bytes;
    logic                rsp_valid;
    logic                rsp_ready;
    logic [STATUS_W-1:0] status;
    logic [OFF_W-1:0]    byte_offset;

    // predictor state: shadow used-block bitmap
    logic [MAP_WORD_BITS-1:0] shadow_map [MAP_WORDS];
    int free_blocks;

    alloc_result_t pending_allocs[$];

    int error_count;
    int mismatch_count;
    int requests_sent;
    int allocated_seen;
    int zero_size_seen;
    int no_space_seen;
    int results_seen;
    int stalls_done;

    // idling controls shared by the test tasks and the response side
    bit send_eager;
    bit recv_eager;
    int rsp_hold_cycles;

    bitmap_first_fit_allocator #(
        .NUM_BLOCKS    (NUM_BLOCKS),
        .BLOCK_BYTES   (BLOCK_BYTES),
        .MAP_WORD_BITS (MAP_WORD_BITS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .size_bytes  (size_bytes),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .status      (status),
        .byte_offset (byte_offset)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // first-fit search over the shadow bitmap, marks the run it returns
    function automatic alloc_result_t first_fit(input logic [SIZE_W-1:0] sz);
        alloc_result_t r;
        int need;
        int run;
        int start;
        r.status = STATUS_NO_SPACE;
        r.offset = '0;
        if (sz == '0)
        begin
            r.status = STATUS_ZERO_SIZE;
            return r;
        end
        need = (int'(sz) + BLOCK_BYTES - 1) / BLOCK_BYTES;
        if (need > NUM_BLOCKS)
            return r;
        run = 0;
        for (int blk = 0; blk < NUM_BLOCKS; blk++)
        begin
            if (shadow_map[blk / MAP_WORD_BITS][blk % MAP_WORD_BITS])
                run = 0;
            else
            begin
                run++;
                if (run == need)
                begin
                    start = blk + 1 - need;
                    for (int k = start; k <= blk; k++)
                        shadow_map[k / MAP_WORD_BITS][k % MAP_WORD_BITS] = 1'b1;
                    free_blocks -= need;
                    r.status = STATUS_ALLOCATED;
                    r.offset = OFF_W'(start * BLOCK_BYTES);
                    return r;
                end
            end
        end
        return r;
    endfunction

    // send one request beat and record what it should allocate
    task automatic send_request(input logic [SIZE_W-1:0] sz);
        int gap;
        gap = send_eager ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid  <= 1'b1;
        size_bytes <= sz;
        do
            @(posedge clk);
        while (!req_ready);
        pending_allocs.push_back(first_fit(sz));
        requests_sent++;
    endtask

    // drop the request valid once the last beat went through
    task automatic release_request();
        @(negedge clk);
        req_valid <= 1'b0;
    endtask

    // wait, bounded, until every outstanding response came back
    task automatic wait_for_results();
        int waited;
        waited = 0;
        while (pending_allocs.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_allocs.size() != 0)
        begin
            $display("error: %0d responses never arrived", pending_allocs.size());
            error_count += pending_allocs.size();
            pending_allocs.delete();
        end
    endtask

    // response side: random ready gaps, optional long hold-off, compare
    initial
    begin
        int wait_left;
        bit take;
        alloc_result_t exp_r;
        rsp_ready = 1'b0;
        wait_left = 0;
        forever
        begin
            @(negedge clk);
            take = (wait_left == 0) && (rsp_hold_cycles == 0) && rst_n;
            rsp_ready <= take;
            if (wait_left > 0)
                wait_left--;
            @(posedge clk);
            if (take && rsp_valid)
            begin
                results_seen++;
                wait_left = recv_eager ? 0 : $urandom_range(0, MAX_GAP);
                if (pending_allocs.size() == 0)
                begin
                    error_count++;
                    if (mismatch_count < 10)
                        $display("error: response with nothing outstanding, status %0d offset %0d",
                                 status, byte_offset);
                    mismatch_count++;
                end
                else
                begin
                    exp_r = pending_allocs.pop_front();
                    case (status)
                        STATUS_ALLOCATED: allocated_seen++;
                        STATUS_ZERO_SIZE: zero_size_seen++;
                        default:          no_space_seen++;
                    endcase
                    if (status !== exp_r.status || byte_offset !== exp_r.offset)
                    begin
                        error_count++;
                        if (mismatch_count < 10)
                            $display("mismatch on response %0d: expected status %0d offset %0d, got status %0d offset %0d",
                                     results_seen, exp_r.status, exp_r.offset,
                                     status, byte_offset);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // hold-off counter for the response side
    always @(posedge clk)
    begin
        if (rsp_hold_cycles > 0)
            rsp_hold_cycles <= rsp_hold_cycles - 1;
    end

    // zero, one-block edges, rounding edges and oversize requests
    task automatic test_size_extremes();
        logic [SIZE_W-1:0] sizes [$];
        sizes = '{16'd0, 16'd1, 16'd7, 16'd8, 16'd9, 16'd15, 16'd16, 16'd17,
                  16'd64, 16'd65, 16'd255, 16'd256, 16'd1024,
                  16'(POOL_BYTES + 1), 16'd40000, 16'hFFFF, 16'h8001, 16'd0, 16'd1};
        foreach (sizes[i])
            send_request(sizes[i]);
        release_request();
        wait_for_results();
    endtask

    // long output stall while requests keep coming, so the input backs up
    task automatic test_output_stall();
        send_eager = 1'b1;
        @(negedge clk);
        rsp_hold_cycles = 600;
        for (int i = 0; i < 24; i++)
            send_request(16'($urandom_range(1, 24)));
        send_eager = 1'b0;
        stalls_done++;
        release_request();
        wait_for_results();
    endtask

    // sender stops until everything is back, then resumes
    task automatic test_sender_pause();
        for (int i = 0; i < 6; i++)
            send_request(16'($urandom_range(1, 40)));
        release_request();
        wait_for_results();
        for (int i = 0; i < 6; i++)
            send_request(16'($urandom_range(0, 40)));
        release_request();
        wait_for_results();
    endtask

    // mostly small allocations with some zero, medium and oversize noise
    task automatic test_random_requests();
        int pick;
        logic [SIZE_W-1:0] sz;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // new idling pattern every so often, including gap-free stretches
            if (i % 64 == 0)
            begin
                send_eager = ($urandom_range(0, 3) == 0);
                recv_eager = ($urandom_range(0, 3) == 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 4)
                sz = '0;
            else if (pick < 12)
                sz = 16'($urandom_range(POOL_BYTES + 1, 65535));
            else if (pick < 15)
                sz = 16'($urandom_range(17, 256));
            else
                sz = 16'($urandom_range(1, 16));
            send_request(sz);
        end
        send_eager = 1'b0;
        recv_eager = 1'b0;
        release_request();
        wait_for_results();
    endtask

    // just-too-large, exact fit up to the last block, then a full pool
    task automatic test_pool_exhaustion();
        int left;
        left = free_blocks;
        if (left > 0)
        begin
            send_request(16'(left * BLOCK_BYTES + 1));
            send_request(16'(left * BLOCK_BYTES - BLOCK_BYTES + 1));
        end
        send_request(16'd1);
        send_request(16'(POOL_BYTES));
        send_request(16'd0);
        release_request();
        wait_for_results();
    endtask

    // main sequence
    initial
    begin
        rst_n           = 1'b0;
        req_valid       = 1'b0;
        size_bytes      = '0;
        send_eager      = 1'b0;
        recv_eager      = 1'b0;
        rsp_hold_cycles = 0;
        error_count     = 0;
        mismatch_count  = 0;
        requests_sent   = 0;
        allocated_seen  = 0;
        zero_size_seen  = 0;
        no_space_seen   = 0;
        results_seen    = 0;
        stalls_done     = 0;
        free_blocks     = NUM_BLOCKS;
        foreach (shadow_map[w])
            shadow_map[w] = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        test_size_extremes();
        test_output_stall();
        test_sender_pause();
        test_random_requests();
        test_pool_exhaustion();

        // let any stray response show up before the verdict
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d requests: %0d allocated, %0d zero-size, %0d out of space",
                 requests_sent, allocated_seen, zero_size_seen, no_space_seen);
        $display("pool ended with %0d free blocks after %0d long output stall(s), %0d errors",
                 free_blocks, stalls_done, error_count);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog
    initial
    begin
        #40_000_000;
        $display("error: run did not complete in time");
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/bffa_pkg.sv
design/bitmap_first_fit_allocator.sv
tb/sv/testbench.sv
